### design/bitmap_page_allocator_top_defines.svh
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_DEFINES_SVH

// assertion helpers, clocked on clk_i and held off during reset
`ifndef SYNTH
`define BPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BPA_ASSERT(lbl, prop, msg)
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### design/bpa_pkg.sv
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int unsigned CFG_W = 13;
  localparam logic [CFG_W-1:0] INIT_PAGES_RST = 13'd8;

  // one memory row holds the used bits of 64 pages
  localparam int unsigned WORD_W = 64;
  localparam int unsigned BIT_W  = 6;

  // x / 5 == (x * 52429) >> 18 for every x below 2**18
  localparam logic [15:0] DIV5_MUL   = 16'd52429;
  localparam int unsigned DIV5_SHIFT = 18;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_ALLOC = 2'd1,
    STAT_RANGE     = 2'd2,
    STAT_NO_SPACE  = 2'd3
  } stat_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

endpackage

### design/bitmap_page_allocator_top.sv
// an accepted item passes through ST_SCAN and ST_COMMIT; out_valid_o rises as ST_COMMIT
//   is left, which waits while a held result is stalled; no new item is taken until then
//   (in_stall_o high), as an item may read-modify-write one 64-page bitmap row
// reset: every page free (row valid bits cleared at once, no clearing pass),
//   capacity 8 pages, initial_pages register 8
`timescale 1ns / 1ps

`include "bitmap_page_allocator_top_defines.svh"

module bitmap_page_allocator_top #(
  parameter int unsigned MAX_PAGES = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bpa_pkg::CFG_W-1:0]        cfg_initial_pages_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       command_i,
  input  logic [$clog2(MAX_PAGES)-1:0]     page_index_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [$clog2(MAX_PAGES)-1:0]     page_index_out_o,
  output logic [1:0]                       status_o,
  output logic [$clog2(MAX_PAGES+1)-1:0]   capacity_pages_o,
  output logic                             grew_o
);

  localparam int unsigned PW = $clog2(MAX_PAGES);
  localparam int unsigned CW = $clog2(MAX_PAGES + 1);
  localparam int unsigned RW = (PW > bpa_pkg::BIT_W) ? PW - bpa_pkg::BIT_W : 1;
  localparam int unsigned NR = 2 ** RW;
  localparam int unsigned XW = RW + bpa_pkg::BIT_W + 1;
  localparam int unsigned LW = (XW > bpa_pkg::CFG_W) ? XW : bpa_pkg::CFG_W;
  localparam int unsigned MW = CW + 17;

  bpa_pkg::state_e state_q, state_d;

  logic [bpa_pkg::CFG_W-1:0]  init_pages_q;
  logic [CW-1:0]              cap_q, cap_d;

  logic [bpa_pkg::WORD_W-1:0] mem_q [NR];
  logic [bpa_pkg::WORD_W-1:0] rd_data_q;
  logic                       rd_vld_q;
  logic [NR-1:0]              vld_q, vld_d;
  logic [NR-1:0]              full_q, full_d;

  bpa_pkg::cmd_e              cmd_q;
  logic [PW-1:0]              idx_q;
  logic [RW-1:0]              row_q;
  logic                       any_free_q;
  logic [bpa_pkg::BIT_W-1:0]  zbit_q;
  logic [XW-1:0]              fp_q;
  logic [CW-1:0]              grown_q;

  logic                       out_valid_q;
  logic [PW-1:0]              page_out_q;
  bpa_pkg::stat_e             status_q;
  logic [CW-1:0]              cap_out_q;
  logic                       grew_q;

  // control decoded from the state
  logic accept, commit;

  // first row that still has a free page
  logic [RW-1:0] first_row;
  logic          any_free;
  logic [RW-1:0] rd_addr;

  // scan stage
  logic [bpa_pkg::WORD_W-1:0] cur_word;
  logic [bpa_pkg::BIT_W-1:0]  zbit;
  logic                       zfound;
  logic [XW-1:0]              fp_d;
  logic [CW:0]                div_n;
  logic [MW-1:0]              div_prod;
  logic [CW:0]                grown_raw;
  logic [CW-1:0]              grown_d;

  // commit stage
  logic [XW-1:0]              scan_lim;
  logic [CW-1:0]              load_val;
  logic                       mem_we;
  logic [RW-1:0]              mem_waddr;
  logic [bpa_pkg::WORD_W-1:0] mem_wdata;
  logic                       clr_all;
  logic [PW-1:0]              page_res;
  bpa_pkg::stat_e             status_res;
  logic                       grew_res;
  logic [CW-1:0]              cap_res;

  assign cfg_ready_o = 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpa_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = bpa_pkg::ST_SCAN;
      end
      bpa_pkg::ST_SCAN: state_d = bpa_pkg::ST_COMMIT;
      bpa_pkg::ST_COMMIT: begin
        if (!out_valid_q || !out_stall_i) state_d = bpa_pkg::ST_IDLE;
      end
      default: state_d = bpa_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_stall_o = 1'b1;
    accept     = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      bpa_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
      end
      bpa_pkg::ST_SCAN: ;
      bpa_pkg::ST_COMMIT: commit = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_comb begin
    first_row = '0;
    for (int i = NR - 1; i >= 0; i--) begin
      if (!full_q[i]) first_row = RW'(i);
    end
    any_free = ~&full_q;
  end

  assign rd_addr = (bpa_pkg::cmd_e'(command_i) == bpa_pkg::CMD_FREE)
                   ? RW'(page_index_i >> bpa_pkg::BIT_W) : first_row;

  // bitmap memory, one row read or written per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (accept) rd_data_q <= mem_q[rd_addr];
  end

  // a row never written since reset or init reads as all free
  assign cur_word = rd_vld_q ? rd_data_q : '0;

  always_comb begin
    zbit   = '0;
    zfound = 1'b0;
    for (int i = bpa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (!cur_word[i]) begin
        zbit   = bpa_pkg::BIT_W'(i);
        zfound = 1'b1;
      end
    end
    fp_d = (any_free_q && zfound) ? XW'({row_q, zbit}) : XW'(MAX_PAGES);
  end

  // grown = cap + ceil(cap / 5), saturated
  always_comb begin
    div_n     = (CW + 1)'(cap_q) + (CW + 1)'(4);
    div_prod  = MW'(div_n) * MW'(bpa_pkg::DIV5_MUL);
    grown_raw = (CW + 1)'(cap_q) + (CW + 1)'(div_prod[bpa_pkg::DIV5_SHIFT +: CW-1]);
    grown_d   = (grown_raw > (CW + 1)'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(grown_raw);
  end

  assign scan_lim = XW'({cap_q[CW-1:3], 3'b000});
  assign load_val = (LW'(init_pages_q) > LW'(MAX_PAGES)) ? CW'(MAX_PAGES)
                                                          : CW'(init_pages_q);

  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = row_q;
    mem_wdata  = cur_word;
    clr_all    = 1'b0;
    page_res   = '0;
    status_res = bpa_pkg::STAT_OK;
    grew_res   = 1'b0;
    cap_res    = cap_q;
    unique case (cmd_q)
      bpa_pkg::CMD_INIT: begin
        clr_all   = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = bpa_pkg::WORD_W'(1);
        cap_res   = load_val;
      end
      bpa_pkg::CMD_ALLOC: begin
        if (fp_q < scan_lim) begin
          mem_we    = 1'b1;
          mem_wdata = cur_word | (bpa_pkg::WORD_W'(1) << zbit_q);
          page_res  = fp_q[PW-1:0];
        end else begin
          cap_res  = grown_q;
          grew_res = grown_q > cap_q;
          if (fp_q < XW'(grown_q)) begin
            mem_we    = 1'b1;
            mem_wdata = cur_word | (bpa_pkg::WORD_W'(1) << zbit_q);
            page_res  = fp_q[PW-1:0];
          end else begin
            status_res = bpa_pkg::STAT_NO_SPACE;
          end
        end
      end
      bpa_pkg::CMD_FREE: begin
        if (XW'(idx_q) >= XW'(cap_q)) begin
          status_res = bpa_pkg::STAT_RANGE;
        end else if (!cur_word[idx_q[bpa_pkg::BIT_W-1:0]]) begin
          status_res = bpa_pkg::STAT_NOT_ALLOC;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = cur_word & ~(bpa_pkg::WORD_W'(1) << idx_q[bpa_pkg::BIT_W-1:0]);
        end
      end
      bpa_pkg::CMD_NOP: ;
      default: ;
    endcase
    if (!commit) mem_we = 1'b0;
  end

  always_comb begin
    vld_d  = vld_q;
    full_d = full_q;
    cap_d  = cap_q;
    if (commit) begin
      cap_d = cap_res;
      if (clr_all) begin
        vld_d  = '0;
        full_d = '0;
      end
      if (mem_we) begin
        vld_d[mem_waddr]  = 1'b1;
        full_d[mem_waddr] = &mem_wdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bpa_pkg::ST_IDLE;
      init_pages_q <= bpa_pkg::INIT_PAGES_RST;
      cap_q        <= CW'(bpa_pkg::INIT_PAGES_RST);
      vld_q        <= '0;
      full_q       <= '0;
      rd_vld_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) init_pages_q <= cfg_initial_pages_i;
      cap_q  <= cap_d;
      vld_q  <= vld_d;
      full_q <= full_d;
      if (accept) rd_vld_q <= vld_q[rd_addr];
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= bpa_pkg::cmd_e'(command_i);
      idx_q      <= page_index_i;
      row_q      <= rd_addr;
      any_free_q <= any_free;
    end
    if (state_q == bpa_pkg::ST_SCAN) begin
      zbit_q  <= zbit;
      fp_q    <= fp_d;
      grown_q <= grown_d;
    end
    if (commit) begin
      page_out_q <= page_res;
      status_q   <= status_res;
      cap_out_q  <= cap_res;
      grew_q     <= grew_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign page_index_out_o = page_out_q;
  assign status_o         = status_q;
  assign capacity_pages_o = cap_out_q;
  assign grew_o           = grew_q;

  `BPA_ASSERT_NEXT(a_busy_after_beat, in_valid_i && !in_stall_o, in_stall_o, "item taken while busy")
  `BPA_ASSERT(a_cap_max, cap_q <= CW'(MAX_PAGES), "capacity above maximum")
  `BPA_ASSERT(a_grew_status, !(out_valid_o && grew_o) || status_o == bpa_pkg::STAT_OK || status_o == bpa_pkg::STAT_NO_SPACE, "growth reported with free error")
  `BPA_ASSERT(a_nospace_page, !(out_valid_o && status_o == bpa_pkg::STAT_NO_SPACE) || page_index_out_o == '0, "page given without space")

endmodule
